FILE: sv/utf8_to_utf16_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Types, status codes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int JOB_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 4;

	localparam logic [26:0] LEAD_OFF_2   = 27'h0003080;
	localparam logic [26:0] LEAD_OFF_3   = 27'h00E2080;
	localparam logic [26:0] LEAD_OFF_4   = 27'h3C82080;
	localparam logic [26:0] PLANE1_BASE  = 27'h0010000;
	localparam logic [26:0] MAX_CODE     = 27'h010FFFF;
	localparam logic [26:0] BMP_MAX      = 27'h000FFFF;
	localparam logic [15:0] SURR_HI_BASE = 16'hD800;
	localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
	localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
	localparam logic [19:0] LOW10_MASK   = 20'h003FF;

	typedef enum logic [1:0] {
		ST_UNIT      = 2'd0,
		ST_ILLEGAL   = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		JOB_UNIT = 2'd0,
		JOB_PAIR = 2'd1,
		JOB_ERR  = 2'd2,
		JOB_EXH  = 2'd3
	} job_kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_last;
	} in_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		status_t     status;
		logic        run_last;
		logic        stream_done;
	} out_item_t;

	// classified sequence handed from front to back
	typedef struct packed {
		job_kind_t   kind;
		logic [19:0] value;
		logic        last;
	} job_t;

endpackage

FILE: sv/u8u16_fifo.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: small register FIFO
// First-word-fall-through queue used between front/back and at the output.
// ----------------------------------------------------------------------------
module u8u16_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wr_data,
	output logic full,
	input  logic pop,
	output T     rd_data,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                store_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: sv/u8u16_front.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: front end
// Gathers bytes of a sequence, checks it and converts it to a code point job.
// ----------------------------------------------------------------------------
module u8u16_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  u8u16_pkg::in_item_t in_item,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	output logic                job_push,
	output u8u16_pkg::job_t     job_data,
	input  logic                job_full
);

	logic [7:0]  held_q [4];
	logic [2:0]  need_q;
	logic [2:0]  cnt_q;
	logic        disc_q;
	logic        strict_q;

	logic        accept;
	logic [7:0]  h [4];
	logic [2:0]  need;
	logic [2:0]  len;
	logic        partial;
	logic        legal;
	logic [26:0] sum;
	logic [26:0] ch;
	logic [26:0] ch_sup;
	u8u16_pkg::job_t job;
	logic        job_valid;

	function automatic logic [2:0] trail_count(input logic [7:0] b);
		logic [2:0] r;
		if (b < 8'hC0)      r = 3'd0;
		else if (b < 8'hE0) r = 3'd1;
		else if (b < 8'hF0) r = 3'd2;
		else if (b < 8'hF8) r = 3'd3;
		else if (b < 8'hFC) r = 3'd4;
		else                r = 3'd5;
		return r;
	endfunction

	function automatic logic trailer_ok(input logic [7:0] a);
		return (a >= 8'h80) && (a <= 8'hBF);
	endfunction

	assign accept = push && !job_full;
	assign full   = job_full;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			h[i] = ((cnt_q == 3'(i)) && !cnt_q[2]) ? in_item.in_byte : held_q[i];
		end
		need    = (cnt_q == '0) ? trail_count(in_item.in_byte) : need_q;
		len     = cnt_q + 3'd1;
		partial = (len <= need);

		legal = (len <= 3'd4);
		if (len >= 3'd4 && !trailer_ok(h[3])) legal = 1'b0;
		if (len >= 3'd3 && !trailer_ok(h[2])) legal = 1'b0;
		if (len >= 3'd2) begin
			if (h[1] > 8'hBF) legal = 1'b0;
			case (h[0])
				8'hE0:   if (h[1] < 8'hA0) legal = 1'b0;
				8'hF0:   if (h[1] < 8'h90) legal = 1'b0;
				8'hF4:   if (h[1] < 8'h80 || h[1] > 8'h8F) legal = 1'b0;
				default: if (h[1] < 8'h80) legal = 1'b0;
			endcase
		end
		if (h[0] inside {[8'h80:8'hC1]}) legal = 1'b0;
		if (h[0] > 8'hF4) legal = 1'b0;

		case (len)
			3'd1: sum = {19'd0, h[0]};
			3'd2: sum = ({19'd0, h[0]} << 6) + {19'd0, h[1]} - u8u16_pkg::LEAD_OFF_2;
			3'd3: sum = ({19'd0, h[0]} << 12) + ({19'd0, h[1]} << 6) + {19'd0, h[2]}
				- u8u16_pkg::LEAD_OFF_3;
			3'd4: sum = ({19'd0, h[0]} << 18) + ({19'd0, h[1]} << 12)
				+ ({19'd0, h[2]} << 6) + {19'd0, h[3]} - u8u16_pkg::LEAD_OFF_4;
			default: sum = '0;
		endcase
		ch     = sum;
		ch_sup = ch - u8u16_pkg::PLANE1_BASE;

		job.last  = in_item.stream_last;
		job.value = '0;
		job.kind  = u8u16_pkg::JOB_ERR;
		if (partial) begin
			job.kind = u8u16_pkg::JOB_EXH;
		end else if (!legal) begin
			job.kind = u8u16_pkg::JOB_ERR;
		end else if (ch <= u8u16_pkg::BMP_MAX) begin
			if (strict_q && (ch inside {[27'h000D800:27'h000DFFF]})) begin
				job.kind = u8u16_pkg::JOB_ERR;
			end else begin
				job.kind  = u8u16_pkg::JOB_UNIT;
				job.value = {4'd0, ch[15:0]};
			end
		end else if (ch > u8u16_pkg::MAX_CODE) begin
			// unreachable past the checks; kept for the lenient replacement
			if (strict_q) begin
				job.kind = u8u16_pkg::JOB_ERR;
			end else begin
				job.kind  = u8u16_pkg::JOB_UNIT;
				job.value = {4'd0, u8u16_pkg::REPL_CHAR};
			end
		end else begin
			job.kind  = u8u16_pkg::JOB_PAIR;
			job.value = ch_sup[19:0];
		end

		job_valid = !disc_q && (!partial || in_item.stream_last);
	end

	assign job_push = accept && job_valid;
	assign job_data = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q   <= '0;
			cnt_q    <= '0;
			disc_q   <= 1'b0;
			strict_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				strict_q <= cfg_wdata;
			end
			if (accept) begin
				if (disc_q) begin
					if (in_item.stream_last) disc_q <= 1'b0;
				end else if (partial && !in_item.stream_last) begin
					cnt_q  <= len;
					need_q <= need;
				end else begin
					cnt_q  <= '0;
					need_q <= '0;
					// drop the rest of the stream after an illegal sequence
					if (!partial && job.kind == u8u16_pkg::JOB_ERR && !in_item.stream_last) begin
						disc_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !disc_q && !cnt_q[2]) begin
			held_q[cnt_q[1:0]] <= in_item.in_byte;
		end
	end

endmodule

FILE: sv/u8u16_back.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: back end
// Expands each job into one or two result transactions.
// ----------------------------------------------------------------------------
module u8u16_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_empty,
	input  u8u16_pkg::job_t      job_data,
	output logic                 job_pop,
	output logic                 res_push,
	output u8u16_pkg::out_item_t res_data,
	input  logic                 res_full
);

	logic second_q;
	logic emit;
	logic is_pair;

	assign emit     = !job_empty && !res_full;
	assign is_pair  = (job_data.kind == u8u16_pkg::JOB_PAIR);
	assign res_push = emit;
	// hold the pair job until its low surrogate has gone out
	assign job_pop  = emit && !(is_pair && !second_q);

	always_comb begin
		res_data.code_unit   = '0;
		res_data.status      = u8u16_pkg::ST_UNIT;
		res_data.run_last    = 1'b1;
		res_data.stream_done = job_data.last;
		case (job_data.kind)
			u8u16_pkg::JOB_UNIT: begin
				res_data.code_unit = job_data.value[15:0];
			end
			u8u16_pkg::JOB_PAIR: begin
				if (second_q) begin
					res_data.code_unit = u8u16_pkg::SURR_LO_BASE
						+ {6'd0, job_data.value[9:0]};
				end else begin
					res_data.code_unit   = u8u16_pkg::SURR_HI_BASE
						+ {6'd0, job_data.value[19:10]};
					res_data.run_last    = 1'b0;
					res_data.stream_done = 1'b0;
				end
			end
			u8u16_pkg::JOB_ERR: begin
				res_data.status      = u8u16_pkg::ST_ILLEGAL;
				res_data.stream_done = 1'b1;
			end
			u8u16_pkg::JOB_EXH: begin
				res_data.status      = u8u16_pkg::ST_EXHAUSTED;
				res_data.stream_done = 1'b1;
			end
			default: begin
				res_data.status      = u8u16_pkg::ST_ILLEGAL;
				res_data.stream_done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (emit && is_pair) begin
			second_q <= !second_q;
		end
	end

endmodule

FILE: sv/utf8_to_utf16_decoder_unit.sv
// Path: a byte that completes a sequence is written to the job queue, and the back end then
// expands the job into the result queue; a pair gives its low surrogate after its high one.
// Throughput: one byte per cycle unless the job queue is full; one result per cycle from the back
// end unless the result queue is full; pairs hold it for both units, which the job queue absorbs.
// Reset: arst_n clears both queues, the sequence state and discard flag; strict mode resets to 1.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder unit
// Front end checks and converts byte sequences, back end emits UTF-16 units.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit #(
	parameter int JOB_DEPTH = u8u16_pkg::JOB_DEPTH_DEF,
	parameter int RES_DEPTH = u8u16_pkg::RES_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  u8u16_pkg::in_item_t  in_item,
	output logic                 empty,
	input  logic                 pop,
	output u8u16_pkg::out_item_t out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);

	logic                 job_push;
	logic                 job_full;
	logic                 job_pop;
	logic                 job_empty;
	u8u16_pkg::job_t      job_in;
	u8u16_pkg::job_t      job_out;
	logic                 res_push;
	logic                 res_full;
	u8u16_pkg::out_item_t res_in;

	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.job_push  (job_push),
		.job_data  (job_in),
		.job_full  (job_full)
	);

	u8u16_fifo #(
		.T     (u8u16_pkg::job_t),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.full    (job_full),
		.pop     (job_pop),
		.rd_data (job_out),
		.empty   (job_empty)
	);

	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_data  (job_out),
		.job_pop   (job_pop),
		.res_push  (res_push),
		.res_data  (res_in),
		.res_full  (res_full)
	);

	u8u16_fifo #(
		.T     (u8u16_pkg::out_item_t),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.pop     (pop),
		.rd_data (out_item),
		.empty   (empty)
	);

endmodule

FILE: sv/u8u16_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder: port checker
// Watches the result side of the top level and its bind.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_unit_defines.svh"

module u8u16_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input u8u16_pkg::out_item_t out_item
);

	// error and exhausted results close the stream and carry no unit
	`U8U16_ASSERT_NOW(a_err_closes, clk, arst_n, !empty && out_item.status != u8u16_pkg::ST_UNIT, out_item.run_last && out_item.stream_done && out_item.code_unit == 16'd0)

	// only the high half of a surrogate pair is not the last result of its byte
	`U8U16_ASSERT_NOW(a_mid_is_high, clk, arst_n, !empty && !out_item.run_last, out_item.code_unit[15:10] == 6'b110110 && !out_item.stream_done && out_item.status == u8u16_pkg::ST_UNIT)

	// a high surrogate is followed by its low half
	`U8U16_ASSERT_NEXT(a_pair_follows, clk, arst_n, !empty && pop && !out_item.run_last, out_item.status == u8u16_pkg::ST_UNIT)

	// a waiting result holds until taken
	`U8U16_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_item))

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);

FILE: tb/tb_utf8_to_utf16_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder unit testbench
// Feeds byte streams, directed then random, through the push/full side and
// drains UTF-16 units through the empty/pop side. A scoreboard class keeps
// its own decoder state, builds the units each accepted byte should give and
// compares every popped transaction field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 8;

	// Decoder shadow: sequence state, strict flag and the units still owed
	class utf16_tracker;
		bit [7:0]  seq_bytes [4];
		bit [2:0]  trail_due;
		bit [2:0]  taken;
		bit        discarding;
		bit        strict;
		u8u16_pkg::out_item_t units_due [$];
		int        mismatches;

		function new();
			strict = 1'b1;
		endfunction

		function bit [2:0] trailers_for(bit [7:0] b);
			if (b < 8'hC0) return 3'd0;
			if (b < 8'hE0) return 3'd1;
			if (b < 8'hF0) return 3'd2;
			if (b < 8'hF8) return 3'd3;
			if (b < 8'hFC) return 3'd4;
			return 3'd5;
		endfunction

		function bit is_trailer(bit [7:0] b);
			return b >= 8'h80 && b <= 8'hBF;
		endfunction

		function bit seq_ok(bit [2:0] len);
			bit [7:0] lead;
			bit [7:0] second;
			lead = seq_bytes[0];
			if (len < 3'd1 || len > 3'd4) return 1'b0;
			if (len >= 3'd4 && !is_trailer(seq_bytes[3])) return 1'b0;
			if (len >= 3'd3 && !is_trailer(seq_bytes[2])) return 1'b0;
			if (len >= 3'd2) begin
				second = seq_bytes[1];
				if (second > 8'hBF) return 1'b0;
				case (lead)
					8'hE0: begin
						if (second < 8'hA0) return 1'b0;
					end
					8'hF0: begin
						if (second < 8'h90) return 1'b0;
					end
					8'hF4: begin
						if (second < 8'h80 || second > 8'h8F) return 1'b0;
					end
					default: begin
						if (second < 8'h80) return 1'b0;
					end
				endcase
			end
			if (lead >= 8'h80 && lead < 8'hC2) return 1'b0;
			if (lead > 8'hF4) return 1'b0;
			return 1'b1;
		endfunction

		function void queue_unit(bit [15:0] unit, u8u16_pkg::status_t st, bit rl, bit done);
			u8u16_pkg::out_item_t u;
			u.code_unit   = unit;
			u.status      = st;
			u.run_last    = rl;
			u.stream_done = done;
			units_due.push_back(u);
		endfunction

		function void queue_illegal(bit last);
			if (!last) discarding = 1'b1;
			queue_unit(16'h0000, u8u16_pkg::ST_ILLEGAL, 1'b1, 1'b1);
		endfunction

		// Note one accepted byte and queue the units it should produce
		function void take_byte(u8u16_pkg::in_item_t it);
			bit [7:0]  b;
			bit [2:0]  len;
			bit [31:0] cp;
			int        i;
			b = it.in_byte;
			if (discarding) begin
				if (it.stream_last) discarding = 1'b0;
				return;
			end
			if (taken == 3'd0) trail_due = trailers_for(b);
			if (taken < 3'd4) seq_bytes[taken] = b;
			taken++;
			if (taken <= trail_due) begin
				if (it.stream_last) begin
					taken     = 3'd0;
					trail_due = 3'd0;
					queue_unit(16'h0000, u8u16_pkg::ST_EXHAUSTED, 1'b1, 1'b1);
				end
				return;
			end
			len       = taken;
			taken     = 3'd0;
			trail_due = 3'd0;
			if (!seq_ok(len)) begin
				queue_illegal(it.stream_last);
				return;
			end
			cp = '0;
			for (i = 0; i < len; i++)
				cp = (cp << 6) + 32'(seq_bytes[i]);
			case (len)
				3'd2: cp -= 32'(u8u16_pkg::LEAD_OFF_2);
				3'd3: cp -= 32'(u8u16_pkg::LEAD_OFF_3);
				3'd4: cp -= 32'(u8u16_pkg::LEAD_OFF_4);
				default: ;
			endcase
			if (cp <= 32'(u8u16_pkg::BMP_MAX)) begin
				if (strict && cp >= 32'hD800 && cp <= 32'hDFFF)
					queue_illegal(it.stream_last);
				else
					queue_unit(cp[15:0], u8u16_pkg::ST_UNIT, 1'b1, it.stream_last);
			end else if (cp > 32'(u8u16_pkg::MAX_CODE)) begin
				if (strict)
					queue_illegal(it.stream_last);
				else
					queue_unit(u8u16_pkg::REPL_CHAR, u8u16_pkg::ST_UNIT, 1'b1,
						it.stream_last);
			end else begin
				cp -= 32'(u8u16_pkg::PLANE1_BASE);
				queue_unit(u8u16_pkg::SURR_HI_BASE + 16'(cp[19:10]), u8u16_pkg::ST_UNIT,
					1'b0, 1'b0);
				queue_unit(u8u16_pkg::SURR_LO_BASE + 16'(cp[9:0]), u8u16_pkg::ST_UNIT,
					1'b1, it.stream_last);
			end
		endfunction

		function void match_unit(u8u16_pkg::out_item_t seen);
			u8u16_pkg::out_item_t want;
			if (units_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unit with none due: unit %h status %0d run_last %b done %b",
						$time, seen.code_unit, seen.status, seen.run_last, seen.stream_done);
				return;
			end
			want = units_due.pop_front();
			if (seen.code_unit !== want.code_unit || seen.status !== want.status ||
			    seen.run_last !== want.run_last || seen.stream_done !== want.stream_done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected unit %h status %0d run_last %b done %b, %s %h %0d %b %b",
						$time, want.code_unit, want.status, want.run_last, want.stream_done,
						"got", seen.code_unit, seen.status, seen.run_last, seen.stream_done);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	u8u16_pkg::in_item_t  in_item;
	logic                 empty;
	logic                 pop;
	u8u16_pkg::out_item_t out_item;
	logic                 cfg_we;
	logic                 cfg_wdata;

	utf16_tracker tracker = new();
	bit [7:0]     stream_bytes [$];
	int           fed;
	int           cycles;
	bit           idle_on;
	bit           hold_req;

	utf8_to_utf16_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			tracker.match_unit(out_item);
	end

	// Result side: random pop bursts, plus one long hold-off on request
	initial begin : receiver
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 3);
				pop = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	function automatic void put_code(bit [20:0] cp);
		if (cp < 21'h80) begin
			stream_bytes.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			stream_bytes.push_back({3'b110, cp[10:6]});
			stream_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			stream_bytes.push_back({4'b1110, cp[15:12]});
			stream_bytes.push_back({2'b10, cp[11:6]});
			stream_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			stream_bytes.push_back({5'b11110, cp[20:18]});
			stream_bytes.push_back({2'b10, cp[17:12]});
			stream_bytes.push_back({2'b10, cp[11:6]});
			stream_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	function automatic bit [7:0] trail_byte();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// Broken sequences of every kind the checks reject
	function automatic void add_noise();
		bit [7:0] lead;
		case ($urandom_range(0, 7))
			0: stream_bytes.push_back(8'($urandom));
			1: begin
				put_code(21'($urandom_range(32'h800, 32'h10FFFF)));
				repeat ($urandom_range(1, 2)) void'(stream_bytes.pop_back());
			end
			2: begin
				stream_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
				if ($urandom_range(0, 1))
					stream_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
				else
					stream_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
			end
			3: begin
				stream_bytes.push_back(8'hE0);
				stream_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
				stream_bytes.push_back(trail_byte());
			end
			4: begin
				stream_bytes.push_back(8'hF0);
				stream_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
				stream_bytes.push_back(trail_byte());
				stream_bytes.push_back(trail_byte());
			end
			5: begin
				stream_bytes.push_back(8'hF4);
				stream_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
				stream_bytes.push_back(trail_byte());
				stream_bytes.push_back(trail_byte());
			end
			6: begin
				stream_bytes.push_back(8'($urandom_range(8'hC0, 8'hC1)));
				stream_bytes.push_back(trail_byte());
			end
			default: begin
				lead = 8'($urandom_range(8'hF5, 8'hFF));
				stream_bytes.push_back(lead);
				repeat (lead < 8'hF8 ? 3 : lead < 8'hFC ? 4 : 5)
					stream_bytes.push_back(trail_byte());
			end
		endcase
	endfunction

	function automatic void add_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			put_code(21'($urandom_range(0, 32'h7F)));
		else if (pick < 42)
			put_code(21'($urandom_range(32'h80, 32'h7FF)));
		else if (pick < 62)
			put_code(21'($urandom_range(32'h800, 32'hFFFF)));
		else if (pick < 70)
			put_code(21'($urandom_range(32'hD800, 32'hDFFF)));
		else if (pick < 88)
			put_code(21'($urandom_range(32'h10000, 32'h10FFFF)));
		else
			add_noise();
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			push = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_byte(bit [7:0] b, bit last);
		u8u16_pkg::in_item_t it;
		it.in_byte     = b;
		it.stream_last = last;
		@(negedge clk);
		push    = 1'b1;
		in_item = it;
		@(posedge clk);
		while (full) @(posedge clk);
		if (!tracker.discarding) fed++;
		tracker.take_byte(it);
	endtask

	task automatic send_stream(bit close);
		int last_i;
		last_i = stream_bytes.size() - 1;
		foreach (stream_bytes[i]) begin
			if (idle_on && $urandom_range(0, 4) == 0)
				idle_cycles($urandom_range(1, 3));
			send_byte(stream_bytes[i], close && i == last_i);
		end
	endtask

	// Drain every owed unit, then let the pipeline empty of ignored bytes
	task automatic settle();
		idle_cycles(1);
		while (tracker.units_due.size() != 0) @(posedge clk);
		idle_cycles(SETTLE_CYCLES);
	endtask

	task automatic write_strict(bit v);
		@(negedge clk);
		push      = 1'b0;
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(posedge clk);
		tracker.strict = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_random(int target, bit pause_mid);
		int  start;
		bit  paused;
		start  = fed;
		paused = 1'b0;
		while (fed - start < target) begin
			stream_bytes.delete();
			repeat ($urandom_range(1, 6)) add_char();
			send_stream(1'b1);
			// hold the input until the result side has caught up
			if (pause_mid && !paused && fed - start >= target / 2) begin
				paused = 1'b1;
				idle_cycles(1);
				while (tracker.units_due.size() != 0) @(posedge clk);
			end
		end
	endtask

	initial begin : stimulus
		arst_n    = 1'b0;
		push      = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		idle_on   = 1'b1;
		hold_req  = 1'b0;
		fed       = 0;
		cycles    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_strict(1'b1);
		// ASCII ends, two-byte, top of BMP, both ends of the supplementary range
		stream_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
			8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_stream(1'b1);
		// surrogate rejected in strict mode, rest of stream dropped
		stream_bytes = '{8'hED, 8'hA0, 8'h80, 8'h41};
		send_stream(1'b1);
		// stream ends mid-sequence
		stream_bytes = '{8'hE2, 8'h82};
		send_stream(1'b1);
		// five-byte form, completed on the final byte
		stream_bytes = '{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80};
		send_stream(1'b1);
		// ASCII byte where a trailer is due
		stream_bytes = '{8'hC3, 8'h41};
		send_stream(1'b1);
		// open a surrogate sequence, switch to lenient, then complete it
		stream_bytes = '{8'hED, 8'hA0};
		send_stream(1'b0);
		settle();
		write_strict(1'b0);
		stream_bytes = '{8'h80};
		send_stream(1'b1);
		run_random(150, 1'b0);

		settle();
		write_strict(1'b1);
		hold_req = 1'b1;
		run_random(150, 1'b1);

		settle();
		write_strict(1'b0);
		idle_on = 1'b0;
		run_random(130, 1'b0);

		settle();
		if (tracker.mismatches == 0 && tracker.units_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/u8u16_pkg.sv
sv/u8u16_fifo.sv
sv/u8u16_front.sv
sv/u8u16_back.sv
sv/utf8_to_utf16_decoder_unit.sv
sv/u8u16_checker.sv
tb/tb_utf8_to_utf16_decoder_unit.sv
